// ===== hdl/rzw_pkg.sv =====
// Package for the robust z-score window outlier detector.
// Holds controller states, command/status structs and register codes.
// No dependencies.
package rzw_pkg;

	localparam int unsigned FEAT_W   = 3;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIVD_W   = 48;
	localparam int unsigned DIVS_W   = 32;
	localparam int unsigned DCNT_W   = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH    = 3'd0,
		CFG_WARM_HISTORY     = 3'd1,
		CFG_RECOMPUTE_PERIOD = 3'd2,
		CFG_POISON_ENABLE    = 3'd3,
		CFG_SKIP_THRESHOLD   = 3'd4,
		CFG_FLAG_THRESHOLD   = 3'd5
	} cfg_idx_t;

	localparam logic [8:0]  RST_WINDOW_LENGTH    = 9'd64;
	localparam logic [8:0]  RST_WARM_HISTORY     = 9'd16;
	localparam logic [15:0] RST_RECOMPUTE_PERIOD = 16'd1;
	localparam logic [31:0] RST_SKIP_THRESHOLD   = 32'd655360;
	localparam logic [31:0] RST_FLAG_THRESHOLD   = 32'd229376;
	localparam logic [31:0] SIGN_FLIP            = 32'h8000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_MOD,
		S_RC_CHECK,
		S_SEL_RD,
		S_SEL_DRAIN,
		S_SEL_DEC,
		S_SEL_MID,
		S_SEL_STORE,
		S_RC_NEXT,
		S_Z_START,
		S_Z_DIV,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic ld_in;
		logic use_rf;
		logic rf_clr;
		logic rf_inc;
		logic vopen_set;
		logic div_start_mod;
		logic div_start_z;
		logic z_clr;
		logic z_load;
		logic sel_init_med;
		logic sel_init_mad;
		logic sel_issue;
		logic sel_decide;
		logic sel_store;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mod_zero;
		logic warm;
		logic fill_zero;
		logic in_range;
		logic issue_last;
		logic bit_zero;
		logic mad_mode;
		logic rf_last;
		logic vopen;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/rzw_in_if.sv =====
// Input channel: one feature sample per transfer.
// Depends on rzw_pkg for field widths.
interface rzw_in_if;
	import rzw_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [FEAT_W-1:0]         feature_index;
	logic signed [DATA_W-1:0]  sample;
	logic                      end_of_vector;
	modport source (output valid, feature_index, sample, end_of_vector, input ready);
	modport sink (input valid, feature_index, sample, end_of_vector, output ready);
endinterface

// ===== hdl/rzw_out_if.sv =====
// Result channel: one score result per transfer.
// Depends on rzw_pkg for field widths.
interface rzw_out_if;
	import rzw_pkg::*;
	logic              valid;
	logic              ready;
	logic [FEAT_W-1:0] feature_echo;
	logic [DATA_W-1:0] z_score;
	logic              feature_flag;
	logic              window_skipped;
	logic              vector_done;
	logic              vector_anomaly;
	logic [DATA_W-1:0] vector_max_z;
	modport source (output valid, feature_echo, z_score, feature_flag, window_skipped,
		vector_done, vector_anomaly, vector_max_z, input ready);
	modport sink (input valid, feature_echo, z_score, feature_flag, window_skipped,
		vector_done, vector_anomaly, vector_max_z, output ready);
endinterface

// ===== hdl/rzw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rzw_pkg for widths.
module rzw_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rzw_pkg::DIVD_W-1:0] dividend,
	input  logic [rzw_pkg::DIVS_W-1:0] divisor,
	output logic                      done,
	output logic [rzw_pkg::DIVD_W-1:0] quotient,
	output logic [rzw_pkg::DIVS_W-1:0] remainder
);
	import rzw_pkg::*;

	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [DIVS_W:0]   sh;
	logic              ge;
	logic [DIVS_W:0]   diff;

	assign sh   = {rem_q, quo_q[DIVD_W-1]};
	assign ge   = sh >= {1'b0, dsr_q};
	assign diff = sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DCNT_W'(1));
			if (start) begin
				cnt_q <= DCNT_W'(DIVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIVS_W-1:0] : sh[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== hdl/rzw_ctrl.sv =====
// Controller state machine: sequences vector-start check, median/MAD
// selection passes, scoring divide and result hand-off. Depends on rzw_pkg.
module rzw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rzw_pkg::dp_status_t  st,
	output rzw_pkg::dp_cmd_t     cmd
);
	import rzw_pkg::*;

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_n = S_PRE;
			end
			S_PRE: begin
				state_n = st.vopen ? S_Z_START : S_MOD;
			end
			S_MOD: begin
				if (st.div_done) state_n = st.mod_zero ? S_RC_CHECK : S_Z_START;
			end
			S_RC_CHECK: begin
				state_n = (st.warm && !st.fill_zero) ? S_SEL_RD : S_RC_NEXT;
			end
			S_SEL_RD: begin
				if (st.issue_last) state_n = S_SEL_DRAIN;
			end
			S_SEL_DRAIN: begin
				state_n = S_SEL_DEC;
			end
			S_SEL_DEC: begin
				if (!st.bit_zero) state_n = S_SEL_RD;
				else state_n = st.mad_mode ? S_SEL_STORE : S_SEL_MID;
			end
			S_SEL_MID: begin
				state_n = S_SEL_RD;
			end
			S_SEL_STORE: begin
				state_n = S_RC_NEXT;
			end
			S_RC_NEXT: begin
				state_n = st.rf_last ? S_Z_START : S_RC_CHECK;
			end
			S_Z_START: begin
				state_n = (st.in_range && st.warm) ? S_Z_DIV : S_FINISH;
			end
			S_Z_DIV: begin
				if (st.div_done) state_n = S_FINISH;
			end
			S_FINISH: begin
				if (st.out_free) state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_in  = in_valid;
			end
			S_PRE: begin
				if (!st.vopen) begin
					cmd.div_start_mod = 1'b1;
					cmd.vopen_set     = 1'b1;
				end
			end
			S_MOD: begin
				cmd.rf_clr = st.div_done;
			end
			S_RC_CHECK: begin
				cmd.use_rf       = 1'b1;
				cmd.sel_init_med = st.warm && !st.fill_zero;
			end
			S_SEL_RD: begin
				cmd.use_rf    = 1'b1;
				cmd.sel_issue = 1'b1;
			end
			S_SEL_DRAIN: begin
				cmd.use_rf = 1'b1;
			end
			S_SEL_DEC: begin
				cmd.use_rf     = 1'b1;
				cmd.sel_decide = 1'b1;
			end
			S_SEL_MID: begin
				cmd.use_rf       = 1'b1;
				cmd.sel_init_mad = 1'b1;
			end
			S_SEL_STORE: begin
				cmd.use_rf    = 1'b1;
				cmd.sel_store = 1'b1;
			end
			S_RC_NEXT: begin
				cmd.use_rf = 1'b1;
				cmd.rf_inc = !st.rf_last;
			end
			S_Z_START: begin
				cmd.z_clr       = 1'b1;
				cmd.div_start_z = st.in_range && st.warm;
			end
			S_Z_DIV: begin
				cmd.z_load = st.div_done;
			end
			S_FINISH: begin
				cmd.finish = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// divider results only land where the sequencer waits for them
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == S_MOD || state_q == S_Z_DIV))
		else $error("divider finished outside a wait state");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item accepted while one is in work");
endmodule

// ===== hdl/rzw_datapath.sv =====
// Datapath: config registers, per-feature window memory and state,
// bitwise rank selection, shared divider and output register.
// Depends on rzw_pkg and rzw_div.
module rzw_datapath #(
	parameter int unsigned NUM_FEATURES = 8,
	parameter int unsigned WINDOW_MAX   = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rzw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rzw_pkg::DATA_W-1:0]        cfg_data,
	input  logic [rzw_pkg::FEAT_W-1:0]        in_feature_index,
	input  logic signed [rzw_pkg::DATA_W-1:0] in_sample,
	input  logic                              in_eov,
	input  rzw_pkg::dp_cmd_t                  cmd,
	output rzw_pkg::dp_status_t               st,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [rzw_pkg::FEAT_W-1:0]        out_feature_echo,
	output logic [rzw_pkg::DATA_W-1:0]        out_z_score,
	output logic                              out_feature_flag,
	output logic                              out_window_skipped,
	output logic                              out_vector_done,
	output logic                              out_vector_anomaly,
	output logic [rzw_pkg::DATA_W-1:0]        out_vector_max_z
);
	import rzw_pkg::*;

	localparam int unsigned AW    = $clog2(WINDOW_MAX);
	localparam int unsigned FW    = $clog2(WINDOW_MAX + 1);
	localparam int unsigned FSW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int unsigned FXW   = (FSW > FEAT_W) ? FSW : FEAT_W;
	localparam int unsigned DEPTH = 1 << (FSW + AW);

	// configuration
	logic [8:0]  wlen_q, warm_q;
	logic [15:0] period_q;
	logic        poison_q;
	logic [31:0] skip_th_q, flag_th_q;

	// per-feature state
	logic [FW-1:0]     fill_q   [NUM_FEATURES];
	logic [AW-1:0]     oldest_q [NUM_FEATURES];
	logic [DATA_W-1:0] center_q [NUM_FEATURES];
	logic [DATA_W-1:0] spread_q [NUM_FEATURES];
	logic [DATA_W-1:0] mem [DEPTH];

	// item and vector state
	logic [FEAT_W-1:0] feat_q;
	logic [DATA_W-1:0] samp_q;
	logic              eov_q;
	logic [FXW-1:0]    rf_q;
	logic              vopen_q;
	logic [15:0]       vc_q;
	logic              run_flag_q;
	logic [DATA_W-1:0] run_max_q;
	logic [DATA_W-1:0] z_q;
	logic              scored_q;

	// selection
	logic [4:0]        bit_q;
	logic [FW-1:0]     i_q, cnt_q, k_q;
	logic [AW-1:0]     pos_q;
	logic [DATA_W-1:0] res_q, med_q, rd_q;
	logic              mad_q, rdv_q;

	// output register
	logic              ov_q;
	logic [FEAT_W-1:0] o_feat_q;
	logic [DATA_W-1:0] o_z_q, o_max_q;
	logic              o_flag_q, o_skip_q, o_done_q, o_anom_q;

	logic [FXW-1:0]    fsel;
	logic [FSW-1:0]    fx;
	logic [FW-1:0]     fill_cur;
	logic [AW-1:0]     old_cur;
	logic [DATA_W-1:0] ctr_cur, spr_cur;
	logic              in_range, warm;
	logic [DATA_W:0]   sdiff, sabs;
	logic [DATA_W-1:0] key, mask;
	logic              match;
	logic [AW-1:0]     pos_nxt, old_nxt;
	logic [FW:0]       wsum;
	logic [AW-1:0]     wpos;
	logic [31:0]       eff_len;
	logic              flag, skip, wr_en, out_free;
	logic [DIVD_W-1:0] dvd;
	logic [DIVS_W-1:0] dvs;
	logic              div_done;
	logic [DIVD_W-1:0] quo;
	logic [DIVS_W-1:0] rem;

	assign fsel     = cmd.use_rf ? rf_q : FXW'(feat_q);
	assign fx       = fsel[FSW-1:0];
	assign fill_cur = fill_q[fx];
	assign old_cur  = oldest_q[fx];
	assign ctr_cur  = center_q[fx];
	assign spr_cur  = spread_q[fx];
	assign in_range = 32'(feat_q) < NUM_FEATURES;
	assign warm     = 32'(fill_cur) >= 32'(warm_q);

	// |sample - center| as signed 32-bit values
	assign sdiff = {samp_q[DATA_W-1], samp_q} - {ctr_cur[DATA_W-1], ctr_cur};
	assign sabs  = sdiff[DATA_W] ? (~sdiff + 1'b1) : sdiff;

	always_comb begin
		logic [DATA_W:0] d;
		d     = {rd_q[DATA_W-1], rd_q} - {med_q[DATA_W-1], med_q};
		key   = mad_q ? (d[DATA_W] ? DATA_W'(~d + 1'b1) : d[DATA_W-1:0]) : (rd_q ^ SIGN_FLIP);
		mask  = ~(32'hFFFF_FFFF >> (5'd31 - bit_q));
		match = (((key ^ res_q) & mask) == '0) && !key[bit_q];
	end

	assign pos_nxt = (pos_q == AW'(WINDOW_MAX - 1)) ? '0 : pos_q + AW'(1);
	assign old_nxt = (old_cur == AW'(WINDOW_MAX - 1)) ? '0 : old_cur + AW'(1);
	assign wsum    = (FW+1)'(old_cur) + (FW+1)'(fill_cur);
	assign wpos    = (wsum >= (FW+1)'(WINDOW_MAX)) ? AW'(wsum - (FW+1)'(WINDOW_MAX))
		: AW'(wsum);
	assign eff_len = (wlen_q == '0) ? 32'd1
		: ((32'(wlen_q) > WINDOW_MAX) ? 32'(WINDOW_MAX) : 32'(wlen_q));

	assign flag     = scored_q && (z_q > flag_th_q);
	assign skip     = poison_q && scored_q && (z_q > skip_th_q);
	assign wr_en    = cmd.finish && in_range && !skip;
	assign out_free = !ov_q || out_ready;

	assign dvd = cmd.div_start_mod ? DIVD_W'(vc_q) : {sabs[DATA_W-1:0], 16'h0000};
	assign dvs = cmd.div_start_mod ? ((period_q == '0) ? 32'd1 : 32'(period_q))
		: ((spr_cur == '0) ? 32'd1 : spr_cur);

	rzw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start_mod || cmd.div_start_z),
		.dividend  (dvd),
		.divisor   (dvs),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (wr_en) mem[{fx, wpos}] <= samp_q;
		if (cmd.sel_issue) rd_q <= mem[{fx, pos_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q     <= RST_WINDOW_LENGTH;
			warm_q     <= RST_WARM_HISTORY;
			period_q   <= RST_RECOMPUTE_PERIOD;
			poison_q   <= 1'b0;
			skip_th_q  <= RST_SKIP_THRESHOLD;
			flag_th_q  <= RST_FLAG_THRESHOLD;
			for (int f = 0; f < NUM_FEATURES; f++) begin
				fill_q[f]   <= '0;
				oldest_q[f] <= '0;
				center_q[f] <= '0;
				spread_q[f] <= '0;
			end
			rf_q       <= '0;
			vopen_q    <= 1'b0;
			vc_q       <= '0;
			run_flag_q <= 1'b0;
			run_max_q  <= '0;
			rdv_q      <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH:    wlen_q    <= cfg_data[8:0];
					CFG_WARM_HISTORY:     warm_q    <= cfg_data[8:0];
					CFG_RECOMPUTE_PERIOD: period_q  <= cfg_data[15:0];
					CFG_POISON_ENABLE:    poison_q  <= cfg_data[0];
					CFG_SKIP_THRESHOLD:   skip_th_q <= cfg_data;
					CFG_FLAG_THRESHOLD:   flag_th_q <= cfg_data;
					default: ;
				endcase
			end
			rdv_q <= cmd.sel_issue;
			if (cmd.rf_clr) rf_q <= '0;
			else if (cmd.rf_inc) rf_q <= rf_q + FXW'(1);
			if (cmd.vopen_set) vopen_q <= 1'b1;
			if (cmd.sel_store) begin
				center_q[fx] <= med_q;
				spread_q[fx] <= (res_q == '0) ? 32'd1 : res_q;
			end
			if (wr_en) begin
				if (32'(fill_cur) + 32'd1 > eff_len) begin
					oldest_q[fx] <= old_nxt;
				end else begin
					fill_q[fx] <= fill_cur + FW'(1);
				end
			end
			if (cmd.finish) begin
				ov_q <= 1'b1;
				if (eov_q) begin
					vc_q       <= vc_q + 16'd1;
					run_flag_q <= 1'b0;
					run_max_q  <= '0;
					vopen_q    <= 1'b0;
				end else if (in_range && flag) begin
					run_flag_q <= 1'b1;
					if (z_q > run_max_q) run_max_q <= z_q;
				end
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			feat_q <= in_feature_index;
			samp_q <= in_sample;
			eov_q  <= in_eov;
		end
		if (cmd.z_clr) begin
			z_q      <= '0;
			scored_q <= 1'b0;
		end else if (cmd.z_load) begin
			z_q      <= (quo[DIVD_W-1:DATA_W] != '0) ? 32'hFFFF_FFFF : quo[DATA_W-1:0];
			scored_q <= 1'b1;
		end
		if (cmd.sel_init_med || cmd.sel_init_mad) begin
			res_q <= '0;
			bit_q <= 5'd31;
			k_q   <= fill_cur >> 1;
			i_q   <= '0;
			pos_q <= old_cur;
			cnt_q <= '0;
			mad_q <= cmd.sel_init_mad;
			if (cmd.sel_init_mad) med_q <= res_q ^ SIGN_FLIP;
		end else if (cmd.sel_decide) begin
			if (k_q >= cnt_q) begin
				res_q[bit_q] <= 1'b1;
				k_q          <= k_q - cnt_q;
			end
			bit_q <= bit_q - 5'd1;
			i_q   <= '0;
			pos_q <= old_cur;
			cnt_q <= '0;
		end else begin
			if (cmd.sel_issue) begin
				i_q   <= i_q + FW'(1);
				pos_q <= pos_nxt;
			end
			if (rdv_q && match) cnt_q <= cnt_q + FW'(1);
		end
		if (cmd.finish) begin
			o_feat_q <= feat_q;
			o_z_q    <= z_q;
			o_flag_q <= flag;
			o_skip_q <= skip;
			o_done_q <= eov_q;
			o_anom_q <= eov_q && (run_flag_q || (in_range && flag));
			o_max_q  <= !eov_q ? '0
				: ((in_range && flag && z_q > run_max_q) ? z_q : run_max_q);
		end
	end

	assign st.div_done   = div_done;
	assign st.mod_zero   = rem == '0;
	assign st.warm       = warm;
	assign st.fill_zero  = fill_cur == '0;
	assign st.in_range   = in_range;
	assign st.issue_last = (i_q + FW'(1)) == fill_cur;
	assign st.bit_zero   = bit_q == '0;
	assign st.mad_mode   = mad_q;
	assign st.rf_last    = rf_q == FXW'(NUM_FEATURES - 1);
	assign st.vopen      = vopen_q;
	assign st.out_free   = out_free;

	assign out_valid          = ov_q;
	assign out_feature_echo   = o_feat_q;
	assign out_z_score        = o_z_q;
	assign out_feature_flag   = o_flag_q;
	assign out_window_skipped = o_skip_q;
	assign out_vector_done    = o_done_q;
	assign out_vector_anomaly = o_anom_q;
	assign out_vector_max_z   = o_max_q;

	// a pass is only decided once the last read has been counted
	a_decide_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_decide |-> !rdv_q)
		else $error("rank decision with a read still in flight");

	a_spread_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_store |=> spread_q[$past(fx)] != '0)
		else $error("stored spread is zero");
endmodule

// ===== hdl/robust_z_window_outlier_detector_core.sv =====
// Top level of the robust z-score window outlier detector.
// Depends on rzw_pkg, rzw_in_if, rzw_out_if, rzw_ctrl and rzw_datapath.
//
//   channel  | dir | transfer moves
//   in_ch    | in  | feature_index, sample, end_of_vector
//   out_ch   | out | feature_echo, z_score, flags, vector verdict
//   cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One item at a time. A scored item waits on the 48-step bit-serial divider; an
// unscored one skips the divide.
// The first item of a vector adds a modulo divide; on a recompute vector each warm
// feature with entries adds median and MAD scans of its window memory, one scan per
// result bit, and each other feature only a check and a step to the next feature.
// Reset is asynchronous and needs no clearing pass. The result sits in an
// output register; a stalled sink holds the next result until it is free.
module robust_z_window_outlier_detector_core #(
	parameter int unsigned NUM_FEATURES = 8,
	parameter int unsigned WINDOW_MAX   = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rzw_in_if.sink                        in_ch,
	rzw_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [rzw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rzw_pkg::DATA_W-1:0]    cfg_data
);
	import rzw_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;
	logic       in_ready;

	rzw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rzw_datapath #(
		.NUM_FEATURES (NUM_FEATURES),
		.WINDOW_MAX   (WINDOW_MAX)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_feature_index   (in_ch.feature_index),
		.in_sample          (in_ch.sample),
		.in_eov             (in_ch.end_of_vector),
		.cmd                (cmd),
		.st                 (st),
		.out_ready          (out_ch.ready),
		.out_valid          (out_ch.valid),
		.out_feature_echo   (out_ch.feature_echo),
		.out_z_score        (out_ch.z_score),
		.out_feature_flag   (out_ch.feature_flag),
		.out_window_skipped (out_ch.window_skipped),
		.out_vector_done    (out_ch.vector_done),
		.out_vector_anomaly (out_ch.vector_anomaly),
		.out_vector_max_z   (out_ch.vector_max_z)
	);

	assign in_ch.ready = in_ready;
endmodule

// ===== verif/tb_robust_z_window_outlier_detector_core.sv =====
// Testbench for robust_z_window_outlier_detector_core: directed and random feature
// vectors against a built-in score predictor, with random idling on both channels.
// Depends on rzw_pkg, rzw_in_if, rzw_out_if and the core RTL.
module tb_robust_z_window_outlier_detector_core;
	timeunit 1ns;
	timeprecision 1ps;
	import rzw_pkg::*;

	localparam int NFEAT = 8;
	localparam int WMAX  = 256;

	typedef struct {
		logic [2:0]  feat;
		logic [31:0] z;
		logic        flag;
		logic        skip;
		logic        done;
		logic        anom;
		logic [31:0] maxz;
	} score_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	rzw_in_if  in_ch();
	rzw_out_if out_ch();

	robust_z_window_outlier_detector_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the block's registers and state
	logic [8:0]  p_wlen, p_warm;
	logic [15:0] p_period;
	logic        p_poison;
	logic [31:0] p_skip_thr, p_flag_thr;
	logic [31:0] win [NFEAT][WMAX];
	int unsigned fill [NFEAT];
	int unsigned oldest [NFEAT];
	logic [31:0] center [NFEAT];
	logic [31:0] spread [NFEAT];
	logic [15:0] vec_count;
	logic [31:0] run_max;
	logic        run_flag;
	bit          vec_open;

	score_t expected_scores[$];
	int errors = 0;
	bit idle_en = 1;
	int long_hold = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] abs_dev(longint a, longint b);
		longint d;
		d = a - b;
		if (d < 0) d = -d;
		return d[31:0];
	endfunction

	function automatic void refresh_stats(int f);
		longint vals [WMAX];
		logic [31:0] devs [WMAX];
		int n, j;
		longint v;
		logic [31:0] u;
		n = fill[f];
		if (n == 0 || n > WMAX) return;
		for (int i = 0; i < n; i++)
			vals[i] = $signed(win[f][(oldest[f] + i) % WMAX]);
		for (int i = 1; i < n; i++) begin
			v = vals[i];
			for (j = i; j > 0 && vals[j-1] > v; j--) vals[j] = vals[j-1];
			vals[j] = v;
		end
		for (int i = 0; i < n; i++) devs[i] = abs_dev(vals[i], vals[n/2]);
		for (int i = 1; i < n; i++) begin
			u = devs[i];
			for (j = i; j > 0 && devs[j-1] > u; j--) devs[j] = devs[j-1];
			devs[j] = u;
		end
		center[f] = vals[n/2][31:0];
		spread[f] = (devs[n/2] != 0) ? devs[n/2] : 32'd1;
	endfunction

	function automatic score_t predict_score(logic [2:0] f, logic [31:0] raw, logic eov);
		score_t r;
		longint unsigned num, q;
		logic [31:0] mad;
		int unsigned elen;
		if (!vec_open) begin
			if (vec_count % ((p_period != 0) ? p_period : 16'd1) == 0)
				for (int i = 0; i < NFEAT; i++)
					if (fill[i] >= p_warm) refresh_stats(i);
			vec_open = 1;
		end
		r = '{feat: f, z: 0, flag: 0, skip: 0, done: eov, anom: 0, maxz: 0};
		if (fill[f] >= p_warm) begin
			mad = (spread[f] != 0) ? spread[f] : 32'd1;
			num = longint'(abs_dev($signed(raw), $signed(center[f]))) << 16;
			q = num / mad;
			r.z = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			r.skip = p_poison && (r.z > p_skip_thr);
			r.flag = r.z > p_flag_thr;
		end
		if (!r.skip) begin
			elen = (p_wlen < 1) ? 1 : (p_wlen > WMAX) ? WMAX : p_wlen;
			win[f][(oldest[f] + fill[f]) % WMAX] = raw;
			fill[f]++;
			if (fill[f] > elen) begin
				oldest[f] = (oldest[f] + 1) % WMAX;
				fill[f]--;
			end
		end
		if (r.flag) begin
			run_flag = 1;
			if (r.z > run_max) run_max = r.z;
		end
		if (eov) begin
			r.anom = run_flag;
			r.maxz = run_max;
			vec_count++;
			run_flag = 0;
			run_max = 0;
			vec_open = 0;
		end
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WINDOW_LENGTH:    p_wlen = val[8:0];
			CFG_WARM_HISTORY:     p_warm = val[8:0];
			CFG_RECOMPUTE_PERIOD: p_period = val[15:0];
			CFG_POISON_ENABLE:    p_poison = val[0];
			CFG_SKIP_THRESHOLD:   p_skip_thr = val;
			CFG_FLAG_THRESHOLD:   p_flag_thr = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [8:0] wl, logic [8:0] wh, logic [15:0] per,
			logic pe, logic [31:0] sk, logic [31:0] fl);
		write_reg(CFG_WINDOW_LENGTH, wl);
		write_reg(CFG_WARM_HISTORY, wh);
		write_reg(CFG_RECOMPUTE_PERIOD, per);
		write_reg(CFG_POISON_ENABLE, pe);
		write_reg(CFG_SKIP_THRESHOLD, sk);
		write_reg(CFG_FLAG_THRESHOLD, fl);
	endtask

	// valid stays high across back-to-back transfers; it only drops for a gap
	task automatic send_sample(logic [2:0] f, logic [31:0] s, logic eov);
		int gap;
		gap = idle_en ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.feature_index <= f;
		in_ch.sample <= s;
		in_ch.end_of_vector <= eov;
		do @(posedge clk); while (!in_ch.ready);
		expected_scores.insert(expected_scores.size(), predict_score(f, s, eov));
	endtask

	task automatic wait_drained();
		@(posedge clk);
		in_ch.valid <= 1'b0;
		while (expected_scores.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// result sink: random stall per transfer, or one long hold-off when requested
	initial begin
		score_t e;
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end else
				stall = idle_en ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (expected_scores.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = expected_scores[0];
				expected_scores.delete(0);
				if (out_ch.feature_echo !== e.feat) begin
					$error("feature_echo exp %0d got %0d", e.feat, out_ch.feature_echo);
					errors++;
				end
				if (out_ch.z_score !== e.z) begin
					$error("z_score exp %h got %h", e.z, out_ch.z_score);
					errors++;
				end
				if (out_ch.feature_flag !== e.flag) begin
					$error("feature_flag exp %0b got %0b", e.flag, out_ch.feature_flag);
					errors++;
				end
				if (out_ch.window_skipped !== e.skip) begin
					$error("window_skipped exp %0b got %0b", e.skip, out_ch.window_skipped);
					errors++;
				end
				if (out_ch.vector_done !== e.done) begin
					$error("vector_done exp %0b got %0b", e.done, out_ch.vector_done);
					errors++;
				end
				if (out_ch.vector_anomaly !== e.anom) begin
					$error("vector_anomaly exp %0b got %0b", e.anom, out_ch.vector_anomaly);
					errors++;
				end
				if (out_ch.vector_max_z !== e.maxz) begin
					$error("vector_max_z exp %h got %h", e.maxz, out_ch.vector_max_z);
					errors++;
				end
			end
		end
	end

	// one vector of 1..8 samples around base; some outliers and some full-range noise
	task automatic send_vector(logic [31:0] base);
		int n;
		logic [31:0] s;
		n = $urandom_range(1, NFEAT);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0:       s = $urandom;
				1:       s = base + $urandom_range(0, 32'h0100_0000);
				default: s = base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			endcase
			send_sample(($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'(i), s, i == n - 1);
		end
	endtask

	task automatic test_extremes();
		// warm with empty window: reset center and spread apply, z saturates
		set_config(9'd0, 9'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 32'd0);
		send_sample(3'd0, 32'h8000_0000, 1'b0);
		send_sample(3'd7, 32'h7FFF_FFFF, 1'b0);
		send_sample(3'd1, 32'h0000_0000, 1'b0);
		send_sample(3'd2, 32'hFFFF_FFFF, 1'b1);
		send_sample(3'd0, 32'h7FFF_FFFF, 1'b0);
		send_sample(3'd7, 32'h8000_0000, 1'b1);
		wait_drained();
		// poisoning on with zero skip threshold: any nonzero z is kept out
		set_config(9'd2, 9'd1, 16'd1, 1'b1, 32'd0, 32'd0);
		for (int i = 0; i < 8; i++)
			send_sample(3'(i), 32'h0001_0000 * i, 1'b0);
		send_sample(3'd3, 32'h0003_0000, 1'b1);
		send_sample(3'd3, 32'h8000_0000, 1'b0);
		send_sample(3'd3, 32'h0003_0000, 1'b0);
		send_sample(3'd5, 32'h5555_AAAA, 1'b0);
		send_sample(3'd6, 32'hAAAA_5555, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phase(int nvec, logic [8:0] wl, logic [8:0] wh,
			logic [15:0] per, logic pe, logic [31:0] sk, logic [31:0] fl);
		logic [31:0] base;
		set_config(wl, wh, per, pe, sk, fl);
		base = $urandom;
		repeat (nvec) send_vector(base);
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_en = 0;
		long_hold = 400;
		repeat (5) send_vector($urandom);
		wait_drained();
		idle_en = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.feature_index <= '0;
		in_ch.sample <= '0;
		in_ch.end_of_vector <= 1'b0;
		p_wlen = RST_WINDOW_LENGTH;
		p_warm = RST_WARM_HISTORY;
		p_period = RST_RECOMPUTE_PERIOD;
		p_poison = 1'b0;
		p_skip_thr = RST_SKIP_THRESHOLD;
		p_flag_thr = RST_FLAG_THRESHOLD;
		for (int i = 0; i < NFEAT; i++) begin
			fill[i] = 0;
			oldest[i] = 0;
			center[i] = 0;
			spread[i] = 0;
		end
		vec_count = 0;
		run_max = 0;
		run_flag = 0;
		vec_open = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_extremes();
		test_random_phase(4, 9'd8, 9'd4, 16'd1, 1'b1, 32'h0005_0000, 32'h0003_0000);
		test_random_phase(3, 9'd511, 9'd300, 16'd65535, 1'b0, 32'd0, 32'd0);
		test_random_phase(3, 9'd1, 9'd1, 16'd3, 1'b1, 32'd0, 32'hFFFF_FFFF);
		test_random_phase(3, 9'd16, 9'd6, 16'd2, 1'b1, 32'h0008_0000, 32'h0002_0000);
		test_random_phase(3, 9'd4, 9'd3, 16'd1, 1'b0, 32'hFFFF_FFFF, 32'h0001_0000);
		test_backpressure();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== robust_z_window_outlier_detector_core.f =====
hdl/rzw_pkg.sv
hdl/rzw_in_if.sv
hdl/rzw_out_if.sv
hdl/rzw_div.sv
hdl/rzw_ctrl.sv
hdl/rzw_datapath.sv
hdl/robust_z_window_outlier_detector_core.sv
verif/tb_robust_z_window_outlier_detector_core.sv
